@@ hdl/work_stealing_job_scheduler_core_macros.svh @@
// Assertion macros shared by the scheduler checker
`ifndef WORK_STEALING_JOB_SCHEDULER_CORE_MACROS_SVH
`define WORK_STEALING_JOB_SCHEDULER_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define WSJ_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WSJ_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hdl/wsjs_pkg.sv @@
// Package: constants, codes and control types of the job scheduler
package wsjs_pkg;
  localparam int unsigned NumWorkers  = 4;
  localparam int unsigned DequeDepth  = 512;
  localparam int unsigned PinnedDepth = 64;
  localparam int unsigned GlobalDepth = 1024;

  localparam int unsigned WW  = (NumWorkers > 1) ? $clog2(NumWorkers) : 1;
  localparam int unsigned DAW = $clog2(DequeDepth);
  localparam int unsigned DCW = DAW + 1;
  localparam int unsigned PAW = $clog2(PinnedDepth);
  localparam int unsigned PCW = PAW + 1;
  localparam int unsigned GAW = $clog2(GlobalDepth);
  localparam int unsigned GCW = GAW + 1;
  localparam int unsigned CPW = 10;
  localparam int unsigned TOKW = 32;

  typedef enum logic [1:0] {
    StOk = 2'd0, StEmpty = 2'd1, StOverflow = 2'd2, StBadIdx = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SrcPinned = 2'd0, SrcOwn = 2'd1, SrcStolen = 2'd2, SrcGlobal = 2'd3
  } source_e;

  typedef enum logic [3:0] {
    SIdle, SDecode, SPinPush, SDqFill, SGlFill, SPinRd, SOwnRd,
    SScan, SStealRd, SGlRd, SWait, SOut
  } state_e;

  // which store the datapath reads or writes
  typedef enum logic [1:0] {
    MemPinned = 2'd0, MemDeque = 2'd1, MemGlobal = 2'd2
  } mem_e;

  // controller -> datapath commands
  typedef struct packed {
    logic   load;        // capture input item
    logic   decode;      // compute derived values
    logic   pin_push;    // write pinned entry
    logic   dq_write;    // write one deque copy
    logic   gl_write;    // write one global copy
    logic   fill_done;   // commit count after a batch
    logic   pin_pop;
    logic   own_pop;
    logic   scan_next;   // advance steal scan
    logic   steal_pop;
    logic   gl_pop;
    logic   capture;     // latch read data into result
    mem_e   rd_sel;
    logic   set_status;
    status_e status;
    logic   res_valid;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic mode;
    logic pinned;
    logic is_worker;
    logic bad_idx;
    logic pin_full;
    logic dq_fits;
    logic gl_fits;
    logic zero_copies;
    logic copy_last;
    logic pin_nonempty;
    logic own_nonempty;
    logic scan_hit;
    logic scan_end;
    logic gl_nonempty;
  } stat_t;
endpackage

@@ hdl/wsjs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module wsjs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

@@ hdl/wsjs_ctrl.sv @@
// Controller: sequences submits, fetches and steal scans
module wsjs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  wsjs_pkg::stat_t st_i,
  output wsjs_pkg::cmd_t  cmd_o
);
  wsjs_pkg::state_e state_q, state_d;
  wsjs_pkg::state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsjs_pkg::SIdle;
      ret_q   <= wsjs_pkg::SIdle;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cmd_o       = '0;
    cmd_o.status = wsjs_pkg::StOk;
    cmd_o.rd_sel = wsjs_pkg::MemPinned;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      wsjs_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = wsjs_pkg::SDecode;
        end
      end
      wsjs_pkg::SDecode: begin
        cmd_o.decode = 1'b1;
        state_d = wsjs_pkg::SPinPush;
      end
      wsjs_pkg::SPinPush: begin
        // decision point; derived values are now registered
        cmd_o.set_status = 1'b1;
        state_d = wsjs_pkg::SOut;
        if (!st_i.mode) begin
          if (st_i.pinned) begin
            if (st_i.pin_full) begin
              cmd_o.status = wsjs_pkg::StOverflow;
            end else begin
              cmd_o.pin_push = 1'b1;
            end
          end else if (st_i.is_worker && st_i.bad_idx) begin
            cmd_o.status = wsjs_pkg::StBadIdx;
          end else if (st_i.zero_copies) begin
            cmd_o.status = wsjs_pkg::StOk;
          end else if (st_i.is_worker && st_i.dq_fits) begin
            state_d = wsjs_pkg::SDqFill;
          end else if (st_i.gl_fits) begin
            state_d = wsjs_pkg::SGlFill;
          end else begin
            cmd_o.status = wsjs_pkg::StOverflow;
          end
        end else begin
          if (st_i.bad_idx) begin
            cmd_o.status = wsjs_pkg::StBadIdx;
          end else if (st_i.pin_nonempty) begin
            cmd_o.pin_pop = 1'b1;
            state_d = wsjs_pkg::SPinRd;
          end else if (st_i.own_nonempty) begin
            cmd_o.own_pop = 1'b1;
            state_d = wsjs_pkg::SOwnRd;
          end else begin
            state_d = wsjs_pkg::SScan;
          end
        end
      end
      wsjs_pkg::SDqFill: begin
        cmd_o.dq_write = 1'b1;
        if (st_i.copy_last) begin
          cmd_o.fill_done = 1'b1;
          state_d = wsjs_pkg::SOut;
        end
      end
      wsjs_pkg::SGlFill: begin
        cmd_o.gl_write = 1'b1;
        if (st_i.copy_last) begin
          cmd_o.fill_done = 1'b1;
          state_d = wsjs_pkg::SOut;
        end
      end
      wsjs_pkg::SPinRd: begin
        cmd_o.rd_sel = wsjs_pkg::MemPinned;
        ret_d = wsjs_pkg::SPinRd;
        state_d = wsjs_pkg::SWait;
      end
      wsjs_pkg::SOwnRd: begin
        cmd_o.rd_sel = wsjs_pkg::MemDeque;
        ret_d = wsjs_pkg::SOwnRd;
        state_d = wsjs_pkg::SWait;
      end
      wsjs_pkg::SScan: begin
        if (st_i.scan_hit) begin
          cmd_o.steal_pop = 1'b1;
          state_d = wsjs_pkg::SStealRd;
        end else if (st_i.scan_end) begin
          cmd_o.set_status = 1'b1;
          if (st_i.gl_nonempty) begin
            cmd_o.gl_pop = 1'b1;
            state_d = wsjs_pkg::SGlRd;
          end else begin
            cmd_o.status = wsjs_pkg::StEmpty;
            state_d = wsjs_pkg::SOut;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      wsjs_pkg::SStealRd: begin
        cmd_o.rd_sel = wsjs_pkg::MemDeque;
        ret_d = wsjs_pkg::SStealRd;
        state_d = wsjs_pkg::SWait;
      end
      wsjs_pkg::SGlRd: begin
        cmd_o.rd_sel = wsjs_pkg::MemGlobal;
        ret_d = wsjs_pkg::SGlRd;
        state_d = wsjs_pkg::SWait;
      end
      wsjs_pkg::SWait: begin
        // read data registered, take it into the result
        cmd_o.capture = 1'b1;
        case (ret_q)
          wsjs_pkg::SPinRd: cmd_o.rd_sel = wsjs_pkg::MemPinned;
          wsjs_pkg::SGlRd:  cmd_o.rd_sel = wsjs_pkg::MemGlobal;
          default:          cmd_o.rd_sel = wsjs_pkg::MemDeque;
        endcase
        state_d = wsjs_pkg::SOut;
      end
      wsjs_pkg::SOut: begin
        out_valid_o = 1'b1;
        cmd_o.res_valid = 1'b1;
        if (out_ready_i) begin
          state_d = wsjs_pkg::SIdle;
        end
      end
      default: state_d = wsjs_pkg::SIdle;
    endcase
  end
endmodule

@@ hdl/wsjs_dp.sv @@
// Datapath: counters, pointers, stores and result register
module wsjs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [2:0]                    cfg_data_i,
  input  logic                          mode_i,
  input  logic [1:0]                    worker_id_i,
  input  logic                          submitter_is_worker_i,
  input  logic                          pinned_i,
  input  logic [7:0]                    target_worker_i,
  input  logic [wsjs_pkg::TOKW-1:0]     job_token_i,
  input  logic [wsjs_pkg::CPW-1:0]      copies_i,
  input  wsjs_pkg::cmd_t                cmd_i,
  output wsjs_pkg::stat_t               st_o,
  output logic [1:0]                    status_o,
  output logic [wsjs_pkg::TOKW-1:0]     job_token_res_o,
  output logic [1:0]                    source_o,
  output logic [1:0]                    source_worker_o
);
  localparam int unsigned NW  = wsjs_pkg::NumWorkers;
  localparam int unsigned WW  = wsjs_pkg::WW;
  localparam int unsigned DAW = wsjs_pkg::DAW;
  localparam int unsigned DCW = wsjs_pkg::DCW;
  localparam int unsigned PAW = wsjs_pkg::PAW;
  localparam int unsigned PCW = wsjs_pkg::PCW;
  localparam int unsigned GAW = wsjs_pkg::GAW;
  localparam int unsigned GCW = wsjs_pkg::GCW;
  localparam int unsigned CPW = wsjs_pkg::CPW;
  localparam int unsigned TW  = wsjs_pkg::TOKW;

  // configuration
  logic [2:0] act_q;
  logic [2:0] eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) act_q <= 3'd4;
    else if (cfg_valid_i) act_q <= cfg_data_i;
  end
  always_comb begin
    eff = act_q;
    if (eff == 3'd0) eff = 3'd1;
    if (32'(eff) > NW) eff = 3'(NW);
  end

  // captured item
  logic          mode_q, wrk_q, pin_q;
  logic [1:0]    wid_q;
  logic [7:0]    tgt_q;
  logic [TW-1:0] tok_q;
  logic [CPW-1:0] cp_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      wid_q  <= worker_id_i;
      wrk_q  <= submitter_is_worker_i;
      pin_q  <= pinned_i;
      tgt_q  <= target_worker_i;
      tok_q  <= job_token_i;
      cp_q   <= copies_i;
    end
  end

  // control state
  logic [DAW-1:0] head_q [NW];
  logic [DCW-1:0] dcnt_q [NW];
  logic [PCW-1:0] pcnt_q [NW];
  logic [WW-1:0]  lv_q   [NW];
  logic [GCW-1:0] gcnt_q;

  // decoded values, registered
  logic [WW-1:0]  tsel_q;   // pinned target after modulo
  logic           bad_q;
  logic [WW-1:0]  w_q;      // worker id narrowed
  logic [CPW-1:0] cidx_q;   // copy counter
  logic [2:0]     scan_q;   // scan position
  logic           pass2_q;
  logic [WW-1:0]  vic_q;

  // target mod 3: base-4 digits summed, then the small sum folded down
  logic [3:0] dig_sum;
  logic [3:0] m3;
  always_comb begin
    dig_sum = 4'(tgt_q[1:0]) + 4'(tgt_q[3:2]) + 4'(tgt_q[5:4]) + 4'(tgt_q[7:6]);
    m3 = dig_sum;
    if (m3 >= 4'd9) m3 = m3 - 4'd9;
    if (m3 >= 4'd6) m3 = m3 - 4'd6;
    if (m3 >= 4'd3) m3 = m3 - 4'd3;
  end

  // target % eff for eff in 1..4
  logic [7:0] tmod;
  always_comb begin
    tmod = tgt_q;
    case (eff)
      3'd1: tmod = 8'd0;
      3'd2: tmod = {7'd0, tgt_q[0]};
      3'd4: tmod = {6'd0, tgt_q[1:0]};
      default: tmod = {6'd0, m3[1:0]};
    endcase
  end

  logic [WW-1:0] w_dec;
  assign w_dec = WW'(wid_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      tsel_q <= WW'(tmod);
      bad_q  <= ({1'b0, wid_q} >= eff);
      w_q    <= w_dec;
    end
  end

  // status toward controller
  logic [DCW:0] dsum;
  logic [GCW:0] gsum;
  assign dsum = (DCW+1)'(dcnt_q[w_q]) + (DCW+1)'(cp_q);
  assign gsum = (GCW+1)'(gcnt_q) + (GCW+1)'(cp_q);

  // steal scan: pass one from last victim to eff-1, pass two 0..min(lv,eff)-1
  logic [2:0] lv_ext, lim;
  assign lv_ext = 3'(lv_q[w_q]);
  logic scan_valid;
  always_comb begin
    if (!pass2_q) begin
      lim = eff;
    end else begin
      lim = (lv_ext < eff) ? lv_ext : eff;
    end
    scan_valid = (scan_q < lim);
  end
  logic [WW-1:0] scan_w;
  assign scan_w = WW'(scan_q);

  always_comb begin
    st_o = '0;
    st_o.mode         = mode_q;
    st_o.pinned       = pin_q;
    st_o.is_worker    = wrk_q;
    st_o.bad_idx      = bad_q;
    st_o.pin_full     = (pcnt_q[tsel_q] >= PCW'(wsjs_pkg::PinnedDepth));
    st_o.dq_fits      = (dsum <= (DCW+1)'(wsjs_pkg::DequeDepth));
    st_o.gl_fits      = (gsum <= (GCW+1)'(wsjs_pkg::GlobalDepth));
    st_o.zero_copies  = (cp_q == '0);
    st_o.copy_last    = (cidx_q == cp_q - CPW'(1));
    st_o.pin_nonempty = (pcnt_q[w_q] != '0);
    st_o.own_nonempty = (dcnt_q[w_q] != '0);
    st_o.scan_hit     = scan_valid && (dcnt_q[scan_w] != '0);
    st_o.scan_end     = !scan_valid && pass2_q;
    st_o.gl_nonempty  = (gcnt_q != '0);
  end

  // memory ports
  logic            dq_we, pn_we, gl_we;
  logic [DAW+WW-1:0] dq_waddr, dq_raddr_d, dq_raddr_q;
  logic [PAW+WW-1:0] pn_waddr, pn_raddr_d, pn_raddr_q;
  logic [GAW-1:0]    gl_waddr, gl_raddr_d, gl_raddr_q;
  logic [TW-1:0]     dq_rd, pn_rd, gl_rd;
  logic [DAW-1:0]    wpos;

  assign wpos     = head_q[w_q] + DAW'(dcnt_q[w_q]) + DAW'(cidx_q);
  assign dq_we    = cmd_i.dq_write;
  assign dq_waddr = {w_q, wpos};
  assign pn_we    = cmd_i.pin_push;
  assign pn_waddr = {tsel_q, PAW'(pcnt_q[tsel_q])};
  assign gl_we    = cmd_i.gl_write;
  assign gl_waddr = GAW'(gcnt_q) + GAW'(cidx_q);

  // read addresses are registered at the pop, then the RAM read follows
  always_comb begin
    dq_raddr_d = dq_raddr_q;
    pn_raddr_d = pn_raddr_q;
    gl_raddr_d = gl_raddr_q;
    if (cmd_i.pin_pop) pn_raddr_d = {w_q, PAW'(pcnt_q[w_q] - PCW'(1))};
    if (cmd_i.own_pop) dq_raddr_d = {w_q, head_q[w_q] + DAW'(dcnt_q[w_q] - DCW'(1))};
    if (cmd_i.steal_pop) dq_raddr_d = {scan_w, head_q[scan_w]};
    if (cmd_i.gl_pop) gl_raddr_d = GAW'(gcnt_q - GCW'(1));
  end
  always_ff @(posedge clk_i) begin
    dq_raddr_q <= dq_raddr_d;
    pn_raddr_q <= pn_raddr_d;
    gl_raddr_q <= gl_raddr_d;
  end

  wsjs_ram #(.Width(TW), .Depth(NW * wsjs_pkg::DequeDepth)) u_dq (
    .clk_i, .we_i(dq_we), .waddr_i(dq_waddr), .wdata_i(tok_q),
    .raddr_i(dq_raddr_q), .rdata_o(dq_rd));
  wsjs_ram #(.Width(TW), .Depth(NW * wsjs_pkg::PinnedDepth)) u_pn (
    .clk_i, .we_i(pn_we), .waddr_i(pn_waddr), .wdata_i(tok_q),
    .raddr_i(pn_raddr_q), .rdata_o(pn_rd));
  wsjs_ram #(.Width(TW), .Depth(wsjs_pkg::GlobalDepth)) u_gl (
    .clk_i, .we_i(gl_we), .waddr_i(gl_waddr), .wdata_i(tok_q),
    .raddr_i(gl_raddr_q), .rdata_o(gl_rd));

  // counters, pointers, scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) begin
        head_q[i] <= '0;
        dcnt_q[i] <= '0;
        pcnt_q[i] <= '0;
        lv_q[i]   <= '0;
      end
      gcnt_q  <= '0;
      cidx_q  <= '0;
      scan_q  <= '0;
      pass2_q <= 1'b0;
      vic_q   <= '0;
    end else begin
      if (cmd_i.decode) begin
        cidx_q  <= '0;
        scan_q  <= 3'(lv_q[w_dec]);
        pass2_q <= 1'b0;
      end
      if (cmd_i.pin_push) pcnt_q[tsel_q] <= pcnt_q[tsel_q] + PCW'(1);
      if (cmd_i.dq_write || cmd_i.gl_write) cidx_q <= cidx_q + CPW'(1);
      if (cmd_i.fill_done) begin
        if (cmd_i.dq_write) dcnt_q[w_q] <= dcnt_q[w_q] + DCW'(cp_q);
        else gcnt_q <= gcnt_q + GCW'(cp_q);
      end
      if (cmd_i.pin_pop) pcnt_q[w_q] <= pcnt_q[w_q] - PCW'(1);
      if (cmd_i.own_pop) dcnt_q[w_q] <= dcnt_q[w_q] - DCW'(1);
      if (cmd_i.scan_next) begin
        if (!scan_valid) begin
          pass2_q <= 1'b1;
          scan_q  <= '0;
        end else begin
          scan_q <= scan_q + 3'd1;
        end
      end
      if (cmd_i.steal_pop) begin
        head_q[scan_w] <= head_q[scan_w] + DAW'(1);
        dcnt_q[scan_w] <= dcnt_q[scan_w] - DCW'(1);
        lv_q[w_q]      <= scan_w;
        vic_q          <= scan_w;
      end
      if (cmd_i.gl_pop) gcnt_q <= gcnt_q - GCW'(1);
    end
  end

  // result register
  logic [1:0]    st_q, src_q, srcw_q;
  logic [TW-1:0] res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_q <= wsjs_pkg::StOk; res_q <= '0; src_q <= '0; srcw_q <= '0;
    end
    if (cmd_i.set_status) st_q <= cmd_i.status;
    if (cmd_i.capture) begin
      case (cmd_i.rd_sel)
        wsjs_pkg::MemPinned: begin
          res_q <= pn_rd; src_q <= wsjs_pkg::SrcPinned; srcw_q <= 2'(w_q);
        end
        wsjs_pkg::MemGlobal: begin
          res_q <= gl_rd; src_q <= wsjs_pkg::SrcGlobal; srcw_q <= '0;
        end
        default: begin
          // deque read: stolen unless marked as an own pop below
          res_q <= dq_rd; src_q <= wsjs_pkg::SrcStolen; srcw_q <= 2'(vic_q);
        end
      endcase
    end
  end

  // own vs stolen flag for the deque read
  logic own_rd_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.own_pop) own_rd_q <= 1'b1;
    else if (cmd_i.load) own_rd_q <= 1'b0;
  end

  assign status_o        = st_q;
  assign job_token_res_o = res_q;
  assign source_o        = (cmd_i.res_valid && own_rd_q) ? wsjs_pkg::SrcOwn : src_q;
  assign source_worker_o = (cmd_i.res_valid && own_rd_q) ? 2'(w_q) : srcw_q;
endmodule

@@ hdl/work_stealing_job_scheduler_core.sv @@
// Top level of the work-stealing job scheduler
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_axis_tvalid/tready    | tuser: mode; tdata: other item fields
//  m_axis    | out | m_axis_tvalid/tready    | tdata: result fields
//  cfg       | in  | cfg_valid_i/cfg_ready_o | active_workers (3 bits)
// One item at a time; each item passes idle, decode and the decision state, then:
//   pinned, rejected or zero-copy submit goes to output; batch submit writes its copies;
//   fetch from pinned stack or own deque reads, waits and outputs; steal or global fetch
//   first scans (one probe per deque, one step per pass end), then reads and waits.
// Reset clears counts, pointers, last victims and active_workers (4); stores need no clearing.
// Output stall holds the result; no item is taken until it leaves.
module work_stealing_job_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // [2:0] active_workers
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // [0] mode
  // [1:0] worker_id, [2] submitter_is_worker, [3] pinned,
  // [11:4] target_worker, [43:12] job_token, [53:44] copies
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] job_token_res, [35:34] source, [37:36] source_worker
  output logic [39:0] m_axis_tdata
);
  wsjs_pkg::cmd_t  cmd;
  wsjs_pkg::stat_t st;
  logic [1:0]  status, source, source_worker;
  logic [31:0] tok;

  assign cfg_ready_o = 1'b1;

  wsjs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .st_i(st), .cmd_o(cmd));

  wsjs_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_data_i(cfg_data_i[2:0]),
    .mode_i(s_axis_tuser), .worker_id_i(s_axis_tdata[1:0]),
    .submitter_is_worker_i(s_axis_tdata[2]), .pinned_i(s_axis_tdata[3]),
    .target_worker_i(s_axis_tdata[11:4]), .job_token_i(s_axis_tdata[43:12]),
    .copies_i(s_axis_tdata[53:44]),
    .cmd_i(cmd), .st_o(st),
    .status_o(status), .job_token_res_o(tok),
    .source_o(source), .source_worker_o(source_worker));

  assign m_axis_tdata = {2'b00, source_worker, source, tok, status};
endmodule

@@ hdl/wsjs_chk.sv @@
// Port-level checker for the scheduler, bound to the top level
`include "work_stealing_job_scheduler_core_macros.svh"
module wsjs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  logic out_stall, in_acc, res_err, tok_zero;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign res_err   = (m_axis_tdata[1:0] != 2'd0);
  assign tok_zero  = (m_axis_tdata[33:2] == 32'd0);

  // no new item while a result waits
  `WSJ_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // a stalled result holds
  `WSJ_ASSERT_NXT(a_hold, clk_i, rst_ni, out_stall, $stable(m_axis_tdata))
  // an accepted item never gives a result in the next cycle
  `WSJ_ASSERT_NXT(a_latency, clk_i, rst_ni, in_acc, !m_axis_tvalid)
  // a non-ok status carries a zero token
  `WSJ_ASSERT_IMP(a_zero_tok, clk_i, rst_ni, m_axis_tvalid && res_err, tok_zero)
endmodule

bind work_stealing_job_scheduler_core wsjs_chk u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
